// ===== rtl/race_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and codes for the recent access chunk eviction block.
// Used by the channel interfaces, the top level and the bench.
package race_pkg;

  localparam int NUM_SLOTS_DEF  = 4;
  localparam int MAX_CHUNKS_DEF = 16;
  localparam int ID_BITS_DEF    = 16;

  localparam int OPCODE_W = 2;
  localparam int CHUNK_W  = 16;
  localparam int CFG_W    = 3;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_END   = 2'd1,
    OP_QUERY = 2'd2
  } opcode_t;

endpackage

// ===== rtl/race_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces: request, response and configuration write.
// Field widths come from race_pkg.
interface race_req_if;
  logic                          valid;
  logic                          ready;
  logic [race_pkg::OPCODE_W-1:0] opcode;
  logic [race_pkg::CHUNK_W-1:0]  chunk_id;

  modport source (output valid, output opcode, output chunk_id, input ready);
  modport sink (input valid, input opcode, input chunk_id, output ready);
endinterface

interface race_rsp_if;
  logic valid;
  logic ready;
  logic toss;
  logic changed;
  logic overflow;

  modport source (output valid, output toss, output changed, output overflow, input ready);
  modport sink (input valid, input toss, input changed, input overflow, output ready);
endinterface

interface race_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [race_pkg::CFG_W-1:0] active_ios;

  modport source (output valid, output active_ios, input ready);
  modport sink (input valid, input active_ios, output ready);
endinterface

// ===== rtl/race_store.sv =====
`timescale 1ns / 1ps
// Id storage: slot id memory and staging id memory, one write and one
// registered read port each. No package dependency.
module race_store #(
  parameter int SLOT_ADDR_W = 6,
  parameter int STG_ADDR_W  = 4,
  parameter int ID_W        = 16
) (
  input  logic                   clk,
  input  logic                   slot_we,
  input  logic [SLOT_ADDR_W-1:0] slot_waddr,
  input  logic [ID_W-1:0]        slot_wdata,
  input  logic [SLOT_ADDR_W-1:0] slot_raddr,
  output logic [ID_W-1:0]        slot_rdata,
  input  logic                   stg_we,
  input  logic [STG_ADDR_W-1:0]  stg_waddr,
  input  logic [ID_W-1:0]        stg_wdata,
  input  logic [STG_ADDR_W-1:0]  stg_raddr,
  output logic [ID_W-1:0]        stg_rdata
);

  logic [ID_W-1:0] slot_mem [2**SLOT_ADDR_W];
  logic [ID_W-1:0] stg_mem  [2**STG_ADDR_W];

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    slot_rdata <= slot_mem[slot_raddr];
  end

  always_ff @(posedge clk) begin
    if (stg_we) begin
      stg_mem[stg_waddr] <= stg_wdata;
    end
    stg_rdata <= stg_mem[stg_raddr];
  end

endmodule

// ===== rtl/recent_access_chunk_eviction.sv =====
`timescale 1ns / 1ps
// Top level: sequencer, slot counts and result register of the eviction filter.
// Depends on race_pkg, race_if and race_store.
//
//  channel | dir | transaction     | fields
//  req     | in  | one operation   | opcode, chunk_id
//  rsp     | out | one result      | toss, changed, overflow
//  cfg     | in  | register write  | active_ios
//
// Push and unknown opcodes, and a query with no slot change, go from idle to done.
// End of access goes through the end state and, on a replace, through the copy
// state, which moves the staging list into the slot.
// A query after a change scans the slot memory over the active slots,
// at most one slot memory read per cycle.
// Reset is synchronous; no clearing pass. A stalled rsp holds the result
// register; req is taken again while it waits, until the next result is ready.
module recent_access_chunk_eviction #(
  parameter int NUM_SLOTS             = race_pkg::NUM_SLOTS_DEF,
  parameter int MAX_CHUNKS_PER_ACCESS = race_pkg::MAX_CHUNKS_DEF,
  parameter int ID_BITS               = race_pkg::ID_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  race_req_if.sink    req,
  race_rsp_if.source  rsp,
  race_cfg_if.sink    cfg
);

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int SCNT_W = $clog2(NUM_SLOTS + 1);
  localparam int K_W    = (MAX_CHUNKS_PER_ACCESS > 1) ? $clog2(MAX_CHUNKS_PER_ACCESS) : 1;
  localparam int CNT_W  = $clog2(MAX_CHUNKS_PER_ACCESS + 1);
  localparam int ID_W   = (ID_BITS < race_pkg::CHUNK_W) ? ID_BITS : race_pkg::CHUNK_W;
  localparam int ADDR_W = SLOT_W + K_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_END  = 5'b00010,
    S_COPY = 5'b00100,
    S_SCAN = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t                      state;
  logic [race_pkg::CFG_W-1:0]  active_ios;
  logic [CNT_W-1:0]            slot_counts [NUM_SLOTS];
  logic [CNT_W-1:0]            staging_count;
  logic                        staging_dropped;
  logic [SLOT_W-1:0]           ring_pointer;
  logic                        last_changed;
  logic [SLOT_W-1:0]           cur_slot;
  logic [SCNT_W-1:0]           scan_slot;
  logic [CNT_W-1:0]            idx;
  logic                        pend;
  logic [K_W-1:0]              pend_idx;
  logic [ID_W-1:0]             query_id;
  logic                        res_toss;
  logic                        res_changed;
  logic                        res_ovf;
  logic                        out_valid;
  logic                        out_toss;
  logic                        out_changed;
  logic                        out_ovf;

  logic                        accept;
  logic                        cfg_write;
  logic [SCNT_W-1:0]           n;
  logic [SCNT_W-1:0]           n_cfg;
  logic [SLOT_W-1:0]           p_start;
  logic [SCNT_W-1:0]           p_inc;
  logic [SLOT_W-1:0]           ring_next;
  logic [ID_W-1:0]             id_in;
  logic                        stage_room;
  logic                        scan_live;
  logic [CNT_W-1:0]            scan_cnt;
  logic                        scan_issue;
  logic                        scan_done;
  logic                        hit;
  logic                        copy_issue;
  logic                        copy_done;
  logic                        replace;

  logic                        slot_we;
  logic [ADDR_W-1:0]           slot_waddr;
  logic [ADDR_W-1:0]           slot_raddr;
  logic [ID_W-1:0]             slot_rdata;
  logic                        stg_we;
  logic [K_W-1:0]              stg_waddr;
  logic [K_W-1:0]              stg_raddr;
  logic [ID_W-1:0]             stg_rdata;

  race_store #(
    .SLOT_ADDR_W (ADDR_W),
    .STG_ADDR_W  (K_W),
    .ID_W        (ID_W)
  ) u_store (
    .clk        (clk),
    .slot_we    (slot_we),
    .slot_waddr (slot_waddr),
    .slot_wdata (stg_rdata),
    .slot_raddr (slot_raddr),
    .slot_rdata (slot_rdata),
    .stg_we     (stg_we),
    .stg_waddr  (stg_waddr),
    .stg_wdata  (id_in),
    .stg_raddr  (stg_raddr),
    .stg_rdata  (stg_rdata)
  );

  assign req.ready   = (state == S_IDLE);
  assign cfg.ready   = 1'b1;
  assign rsp.valid   = out_valid;
  assign rsp.toss    = out_toss;
  assign rsp.changed = out_changed;
  assign rsp.overflow = out_ovf;

  assign accept    = req.valid && req.ready;
  assign cfg_write = cfg.valid && cfg.ready;

  always_comb begin
    if (active_ios == '0) begin
      n = SCNT_W'(1);
    end else if (32'(active_ios) > NUM_SLOTS) begin
      n = SCNT_W'(NUM_SLOTS);
    end else begin
      n = SCNT_W'(active_ios);
    end
    if (cfg.active_ios == '0) begin
      n_cfg = SCNT_W'(1);
    end else if (32'(cfg.active_ios) > NUM_SLOTS) begin
      n_cfg = SCNT_W'(NUM_SLOTS);
    end else begin
      n_cfg = SCNT_W'(cfg.active_ios);
    end
  end

  always_comb begin
    id_in      = req.chunk_id[ID_W-1:0];
    stage_room = (staging_count < CNT_W'(MAX_CHUNKS_PER_ACCESS));
    p_start    = (SCNT_W'(ring_pointer) < n) ? ring_pointer : '0;
    p_inc      = SCNT_W'(cur_slot) + SCNT_W'(1);
    ring_next  = (p_inc >= n) ? '0 : p_inc[SLOT_W-1:0];

    scan_live  = (scan_slot < n);
    scan_cnt   = scan_live ? slot_counts[scan_slot[SLOT_W-1:0]] : '0;
    scan_issue = scan_live && (idx < scan_cnt);
    scan_done  = !scan_live && !pend;
    hit        = pend && (slot_rdata == query_id);

    copy_issue = (idx < staging_count);
    copy_done  = !copy_issue && !pend;
    replace    = (staging_count == '0) || (slot_counts[cur_slot] == '0) ||
                 (slot_rdata != stg_rdata);

    slot_raddr = (state == S_IDLE) ? {p_start, K_W'(0)}
                                   : {scan_slot[SLOT_W-1:0], idx[K_W-1:0]};
    slot_we    = (state == S_COPY) && pend;
    slot_waddr = {cur_slot, pend_idx};
    stg_raddr  = (state == S_COPY) ? idx[K_W-1:0] : '0;
    stg_we     = accept && (req.opcode == race_pkg::OP_PUSH) && stage_room;
    stg_waddr  = staging_count[K_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      active_ios      <= race_pkg::CFG_W'(1);
      staging_count   <= '0;
      staging_dropped <= 1'b0;
      ring_pointer    <= '0;
      last_changed    <= 1'b0;
      pend            <= 1'b0;
      out_valid       <= 1'b0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        slot_counts[s] <= '0;
      end
    end else begin
      if (rsp.valid && rsp.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_toss    <= 1'b0;
            res_changed <= last_changed;
            res_ovf     <= staging_dropped ||
                           ((req.opcode == race_pkg::OP_PUSH) && !stage_room);
            unique case (req.opcode)
              race_pkg::OP_PUSH: begin
                if (stage_room) begin
                  staging_count <= staging_count + CNT_W'(1);
                end else begin
                  staging_dropped <= 1'b1;
                end
                state <= S_DONE;
              end
              race_pkg::OP_END: begin
                cur_slot <= p_start;
                state    <= S_END;
              end
              race_pkg::OP_QUERY: begin
                if (last_changed) begin
                  query_id  <= id_in;
                  scan_slot <= '0;
                  idx       <= '0;
                  pend      <= 1'b0;
                  state     <= S_SCAN;
                end else begin
                  state <= S_DONE;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_END: begin
          if (replace) begin
            idx   <= '0;
            pend  <= 1'b0;
            state <= S_COPY;
          end else begin
            last_changed    <= 1'b0;
            ring_pointer    <= ring_next;
            res_toss        <= 1'b0;
            res_changed     <= 1'b0;
            res_ovf         <= staging_dropped;
            staging_count   <= '0;
            staging_dropped <= 1'b0;
            state           <= S_DONE;
          end
        end
        S_COPY: begin
          pend     <= copy_issue;
          pend_idx <= idx[K_W-1:0];
          if (copy_issue) begin
            idx <= idx + CNT_W'(1);
          end
          if (copy_done) begin
            slot_counts[cur_slot] <= staging_count;
            last_changed          <= 1'b1;
            ring_pointer          <= ring_next;
            res_toss              <= 1'b0;
            res_changed           <= 1'b1;
            res_ovf               <= staging_dropped;
            staging_count         <= '0;
            staging_dropped       <= 1'b0;
            state                 <= S_DONE;
          end
        end
        S_SCAN: begin
          res_changed <= last_changed;
          res_ovf     <= staging_dropped;
          if (hit) begin
            res_toss <= 1'b0;
            pend     <= 1'b0;
            state    <= S_DONE;
          end else if (scan_done) begin
            res_toss <= 1'b1;
            state    <= S_DONE;
          end else if (scan_issue) begin
            idx  <= idx + CNT_W'(1);
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
            if (scan_live) begin
              scan_slot <= scan_slot + SCNT_W'(1);
              idx       <= '0;
            end
          end
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid   <= 1'b1;
            out_toss    <= res_toss;
            out_changed <= res_changed;
            out_ovf     <= res_ovf;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (cfg_write) begin
        active_ios <= cfg.active_ios;
        for (int s = 0; s < NUM_SLOTS; s++) begin
          if (s >= int'(n_cfg)) begin
            slot_counts[s] <= '0;
          end
        end
        if (SCNT_W'(ring_pointer) >= n_cfg) begin
          ring_pointer <= '0;
        end
      end
    end
  end

  a_scan_after_change: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> last_changed)
    else $error("slot scan running without a changed slot");

  a_stage_bound: assert property (@(posedge clk) disable iff (rst)
    staging_count <= CNT_W'(MAX_CHUNKS_PER_ACCESS))
    else $error("staging count beyond capacity");

  a_ring_in_range: assert property (@(posedge clk) disable iff (rst)
    SCNT_W'(ring_pointer) < n)
    else $error("ring pointer outside active slots");

  a_full_push_flags: assert property (@(posedge clk) disable iff (rst)
    (accept && (req.opcode == race_pkg::OP_PUSH) && !stage_room) |=>
    (staging_dropped && res_ovf))
    else $error("push into full staging list not flagged");

  a_result_issued: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DONE) && (!out_valid || rsp.ready)) |=>
    ((state == S_IDLE) && out_valid))
    else $error("finished transaction not moved to result register");

endmodule

// ===== bench/eviction_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for recent_access_chunk_eviction: mirrors the slot ring and staging
// list, predicts each result and compares it with the rsp channel.
// Depends on race_pkg and the race_if channel interfaces.
module eviction_checker (
  input  logic clk,
  input  logic rst,
  race_req_if  req,
  race_rsp_if  rsp,
  race_cfg_if  cfg,
  output int   fail_count,
  output int   pending,
  output int   toss_count
);

  localparam int SLOTS = race_pkg::NUM_SLOTS_DEF;
  localparam int DEPTH = race_pkg::MAX_CHUNKS_DEF;

  typedef struct packed {
    logic toss;
    logic changed;
    logic overflow;
  } verdict_t;

  logic [race_pkg::CHUNK_W-1:0] slot_id [SLOTS][DEPTH];
  int unsigned                  slot_cnt [SLOTS];
  logic [race_pkg::CHUNK_W-1:0] stage_id [DEPTH];
  int unsigned                  stage_cnt;
  int unsigned                  ring_ptr;
  logic                         last_chg;
  logic                         dropped;
  logic [race_pkg::CFG_W-1:0]   active_reg;
  verdict_t                     verdict_q [$];

  function automatic int unsigned live_slots();
    if (active_reg == 0) return 1;
    if (active_reg > SLOTS) return SLOTS;
    return active_reg;
  endfunction

  function automatic bit id_resident(logic [race_pkg::CHUNK_W-1:0] id);
    for (int s = 0; s < live_slots(); s++) begin
      for (int k = 0; k < slot_cnt[s]; k++) begin
        if (slot_id[s][k] == id) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic clear_model();
    foreach (slot_id[s, k]) slot_id[s][k] = '0;
    foreach (slot_cnt[s]) slot_cnt[s] = 0;
    foreach (stage_id[k]) stage_id[k] = '0;
    stage_cnt  = 0;
    ring_ptr   = 0;
    last_chg   = 1'b0;
    dropped    = 1'b0;
    active_reg = 1;
    verdict_q.delete();
  endtask

  task automatic apply_active_ios(logic [race_pkg::CFG_W-1:0] value);
    active_reg = value;
    for (int s = live_slots(); s < SLOTS; s++) slot_cnt[s] = 0;
    if (ring_ptr >= live_slots()) ring_ptr = 0;
  endtask

  function automatic verdict_t compute_verdict(logic [race_pkg::OPCODE_W-1:0] op,
                                               logic [race_pkg::CHUNK_W-1:0] id);
    verdict_t    v;
    int unsigned n;
    int unsigned p;
    logic        repl;
    v = '0;
    case (op)
      race_pkg::OP_PUSH: begin
        if (stage_cnt < DEPTH) begin
          stage_id[stage_cnt] = id;
          stage_cnt++;
        end else begin
          dropped = 1'b1;
        end
        v.overflow = dropped;
      end
      race_pkg::OP_END: begin
        n = live_slots();
        p = (ring_ptr < n) ? ring_ptr : 0;
        repl = (stage_cnt == 0) || (slot_cnt[p] == 0) || (slot_id[p][0] != stage_id[0]);
        if (repl) begin
          for (int k = 0; k < stage_cnt; k++) slot_id[p][k] = stage_id[k];
          slot_cnt[p] = stage_cnt;
        end
        last_chg = repl;
        ring_ptr = (p + 1 >= n) ? 0 : p + 1;
        v.overflow = dropped;
        stage_cnt = 0;
        dropped = 1'b0;
      end
      race_pkg::OP_QUERY: begin
        v.toss = last_chg && !id_resident(id);
        v.overflow = dropped;
      end
      default: begin
        v.overflow = dropped;
      end
    endcase
    v.changed = last_chg;
    return v;
  endfunction

  always @(posedge clk) begin : monitor
    verdict_t got;
    verdict_t want;
    if (rst) begin
      clear_model();
    end else begin
      if (rsp.valid && rsp.ready) begin
        got = {rsp.toss, rsp.changed, rsp.overflow};
        if (got.toss === 1'b1) toss_count++;
        if (verdict_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result with no transaction waiting: toss=%0b changed=%0b overflow=%0b",
                     $time, got.toss, got.changed, got.overflow);
        end else begin
          want = verdict_q.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch: expected toss=%0b changed=%0b overflow=%0b, %s%0b %0b %0b",
                       $time, want.toss, want.changed, want.overflow,
                       "got toss/changed/overflow=", got.toss, got.changed, got.overflow);
          end
        end
      end
      if (cfg.valid && cfg.ready) apply_active_ios(cfg.active_ios);
      if (req.valid && req.ready) verdict_q.push_back(compute_verdict(req.opcode, req.chunk_id));
    end
    pending = verdict_q.size();
  end

endmodule

// ===== bench/tb_recent_access_chunk_eviction.sv =====
`timescale 1ns / 1ps
// Testbench top for recent_access_chunk_eviction: clock, reset, stimulus and verdict.
// Depends on race_pkg, race_if, the block itself and eviction_checker.
module tb_recent_access_chunk_eviction;

  localparam logic [race_pkg::OPCODE_W-1:0] OP_RESERVED = 2'd3;

  logic clk;
  logic rst;
  bit   idling = 1'b1;
  int   fails;
  int   pending;
  int   tosses;
  int   n_items;
  int   n_push;
  int   n_end;
  int   n_query;
  int   n_other;
  logic [race_pkg::CHUNK_W-1:0] last_first = '0;

  race_req_if req_ch ();
  race_rsp_if rsp_ch ();
  race_cfg_if cfg_ch ();

  recent_access_chunk_eviction DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  eviction_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .cfg        (cfg_ch),
    .fail_count (fails),
    .pending    (pending),
    .toss_count (tosses)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idling && $urandom_range(0, 9) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
    end
  end

  function automatic logic [race_pkg::CHUNK_W-1:0] pick_id();
    if ($urandom_range(0, 4) == 0) return race_pkg::CHUNK_W'($urandom());
    return race_pkg::CHUNK_W'($urandom_range(0, 11));
  endfunction

  function automatic logic [race_pkg::OPCODE_W-1:0] pick_opcode();
    return race_pkg::OPCODE_W'($urandom_range(0, 3));
  endfunction

  // call at a falling edge; returns at the falling edge after the transaction
  task automatic send(input logic [race_pkg::OPCODE_W-1:0] op,
                      input logic [race_pkg::CHUNK_W-1:0] id);
    if (idling && $urandom_range(0, 7) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.opcode   <= op;
    req_ch.chunk_id <= id;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    @(negedge clk);
    n_items++;
    case (op)
      race_pkg::OP_PUSH:  n_push++;
      race_pkg::OP_END:   n_end++;
      race_pkg::OP_QUERY: n_query++;
      default:            n_other++;
    endcase
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_active(input logic [race_pkg::CFG_W-1:0] value);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.active_ios <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_access();
    int r;
    int n;
    int nq;
    logic [race_pkg::CHUNK_W-1:0] first;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      repeat ($urandom_range(1, 4)) send(pick_opcode(), race_pkg::CHUNK_W'($urandom()));
      return;
    end
    if (r < 18) n = 0;
    else if (r < 28) n = $urandom_range(15, 19);
    else n = $urandom_range(1, 5);
    first = ($urandom_range(0, 2) == 0) ? last_first : pick_id();
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0) send(race_pkg::OP_QUERY, pick_id());
      send(race_pkg::OP_PUSH, (k == 0) ? first : pick_id());
    end
    if (n > 0) last_first = first;
    send(race_pkg::OP_END, race_pkg::CHUNK_W'($urandom()));
    nq = $urandom_range(0, 3);
    repeat (nq) send(race_pkg::OP_QUERY, pick_id());
  endtask

  initial begin : stimulus
    logic [race_pkg::CFG_W-1:0] settings [8];
    int phase_end;
    settings = '{3'd4, 3'd2, 3'd0, 3'd3, 3'd7, 3'd1, 3'd5, 3'd4};
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.opcode     = race_pkg::OP_PUSH;
    req_ch.chunk_id   = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.active_ios = 3'd1;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send(race_pkg::OP_QUERY, 16'h1234);
    send(race_pkg::OP_PUSH, 16'h0000);
    send(race_pkg::OP_PUSH, 16'hFFFF);
    send(race_pkg::OP_END, 16'h0000);
    send(race_pkg::OP_QUERY, 16'hFFFF);
    send(race_pkg::OP_QUERY, 16'h5555);
    send(race_pkg::OP_PUSH, 16'h0000);
    send(race_pkg::OP_END, 16'hFFFF);
    send(race_pkg::OP_QUERY, 16'h5555);
    send(race_pkg::OP_END, 16'h0000);
    send(OP_RESERVED, 16'hAAAA);
    for (int k = 0; k < 17; k++) send(race_pkg::OP_PUSH, race_pkg::CHUNK_W'(k));
    send(race_pkg::OP_END, 16'h0000);
    send(race_pkg::OP_QUERY, 16'h0005);

    foreach (settings[i]) begin
      drain();
      write_active(settings[i]);
      if (i == 7) idling = 1'b0;
      phase_end = n_items + 152;
      while (n_items < phase_end) run_access();
    end

    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    $display("Covered %0d transactions: %0d pushes, %0d access ends, %0d queries, %0d reserved.",
             n_items, n_push, n_end, n_query, n_other);
    $display("active_ios taken through 1, 4, 2, 0, 3, 7, 1, 5, 4; %0d chunks tossed.", tosses);
    if (fails == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/race_pkg.sv
rtl/race_if.sv
rtl/race_store.sv
rtl/recent_access_chunk_eviction.sv
bench/eviction_checker.sv
bench/tb_recent_access_chunk_eviction.sv
